@@ hw/rtl/ifmt_pkg.sv @@
// Shared types, character codes and conversion codes for the integer field formatter.
// No dependencies; every other file of the block imports this package.
package ifmt_pkg;

  // Most digits of a 64-bit value in any supported radix (octal needs 22).
  localparam int DIGITS_MAX  = 22;
  localparam int ND_W        = $clog2(DIGITS_MAX + 1);
  localparam int QUEUE_DEPTH = 2;

  // Conversion kinds as they arrive on the request.
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;
  localparam logic [2:0] KIND_PTR  = 3'd5;

  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_PLUS     = 8'd43;
  localparam logic [7:0] CHAR_MINUS    = 8'd45;
  localparam logic [7:0] CHAR_LOWER_X  = 8'd120;
  localparam logic [7:0] CHAR_UPPER_X  = 8'd88;
  localparam logic [7:0] HEX_LOWER_OFS = 8'd87;
  localparam logic [7:0] HEX_UPPER_OFS = 8'd55;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value_bits;
    logic        is_long;
    logic [5:0]  field_width;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
    logic        alt_prefix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One converted field, ready to be spelled out character by character.
  typedef struct packed {
    logic [DIGITS_MAX-1:0][3:0] digits;   // least significant digit at index 0
    logic [ND_W-1:0]            nd;
    logic                       has_sign;
    logic [7:0]                 sign_char;
    logic [1:0]                 npre;
    logic [7:0]                 pfx_last; // final prefix character
    logic                       upper;
    logic [5:0]                 width;    // already saturated
    logic                       left;
    logic                       zpad;
  } field_desc_t;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LPAD, B_SIGN, B_PREFIX, B_ZPAD, B_DIGIT, B_RPAD
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ofs;
    ofs = upper ? HEX_UPPER_OFS : HEX_LOWER_OFS;
    return (d <= 4'd9) ? (CHAR_ZERO + {4'd0, d}) : (ofs + {4'd0, d});
  endfunction

endpackage

@@ hw/rtl/ifmt_front.sv @@
// Front end: accepts requests, classifies them and converts the value to digits.
// Depends on ifmt_pkg. Decimal goes through a shift-and-add-3 loop, one bit per cycle.
module ifmt_front #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ifmt_pkg::in_item_t        request,
  output logic                      q_push,
  input  logic                      q_full,
  output ifmt_pkg::field_desc_t     q_desc
);
  import ifmt_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int EXT_W = 4 * DIGITS_MAX;
  localparam logic [VALUE_BITS-1:0] LOW32 = VALUE_BITS'(64'h0000_0000_FFFF_FFFF);
  localparam logic [5:0] WIDTH_CAP = 6'(MAX_WIDTH);

  front_state_t state, state_next;
  field_desc_t  pend;
  logic [VALUE_BITS-1:0] shifter;
  logic [CNT_W-1:0]      count;

  logic                  take, kind_ok, is_dec, is_oct, is_hex, wide, neg, is_zero;
  logic [VALUE_BITS-1:0] vb, msk, mag, mag_abs;
  logic [EXT_W-1:0]      ext;
  field_desc_t           load;
  logic [DIGITS_MAX-1:0][3:0] adj, dd_next;
  logic [ND_W-1:0]       nd;

  assign take = push && (state == F_IDLE);

  // Classify the request.
  always_comb begin
    kind_ok = 1'b1;
    is_dec  = 1'b0;
    is_oct  = 1'b0;
    is_hex  = 1'b0;
    unique case (request.kind) inside
      KIND_SDEC, KIND_UDEC:           is_dec = 1'b1;
      KIND_OCT:                       is_oct = 1'b1;
      KIND_HEXL, KIND_HEXU, KIND_PTR: is_hex = 1'b1;
      default:                        kind_ok = 1'b0;
    endcase
  end

  always_comb begin
    wide    = (request.kind == KIND_PTR) || request.is_long;
    vb      = request.value_bits[VALUE_BITS-1:0];
    msk     = wide ? {VALUE_BITS{1'b1}} : LOW32;
    mag     = vb & msk;
    neg     = (request.kind == KIND_SDEC) && (wide ? vb[VALUE_BITS-1] : vb[31]);
    mag_abs = neg ? ((~mag + 1'b1) & msk) : mag;
    is_zero = (mag == '0);
    ext     = EXT_W'(mag_abs);

    load = '0;
    for (int i = 0; i < DIGITS_MAX; i++) begin
      if (is_hex)      load.digits[i] = ext[4*i +: 4];
      else if (is_oct) load.digits[i] = {1'b0, ext[3*i +: 3]};
    end
    load.nd        = ND_W'(1);
    load.has_sign  = neg || ((request.kind == KIND_SDEC) &&
                             (request.force_plus || request.space_sign));
    load.sign_char = neg ? CHAR_MINUS : (request.force_plus ? CHAR_PLUS : CHAR_SPACE);
    if (request.kind == KIND_PTR)
      load.npre = 2'd2;
    else if (is_hex && request.alt_prefix && !is_zero)
      load.npre = 2'd2;
    else if (is_oct && request.alt_prefix && !is_zero)
      load.npre = 2'd1;
    else
      load.npre = 2'd0;
    load.pfx_last = is_oct ? CHAR_ZERO :
                    ((request.kind == KIND_HEXU) ? CHAR_UPPER_X : CHAR_LOWER_X);
    load.upper    = (request.kind == KIND_HEXU);
    load.width    = (request.field_width > WIDTH_CAP) ? WIDTH_CAP : request.field_width;
    load.left     = request.left_justify;
    load.zpad     = request.zero_pad;
  end

  // One double-dabble step: correct each BCD digit, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < DIGITS_MAX; i++)
      adj[i] = (pend.digits[i] >= 4'd5) ? (pend.digits[i] + 4'd3) : pend.digits[i];
    dd_next[0] = {adj[0][2:0], shifter[VALUE_BITS-1]};
    for (int i = 1; i < DIGITS_MAX; i++)
      dd_next[i] = {adj[i][2:0], adj[i-1][3]};
  end

  // Digit count: highest nonzero digit, at least one.
  always_comb begin
    nd = ND_W'(1);
    for (int i = 0; i < DIGITS_MAX; i++)
      if (pend.digits[i] != 4'd0) nd = ND_W'(i + 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (push && kind_ok) state_next = is_dec ? F_CONV : F_PUSH;
      end
      F_CONV: begin
        if (count == CNT_W'(1)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full      = (state != F_IDLE);
    q_push    = (state == F_PUSH);
    q_desc    = pend;
    q_desc.nd = nd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        count <= wide ? CNT_W'(VALUE_BITS) : CNT_W'(32);
      end else if (state == F_CONV) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend    <= load;
      shifter <= wide ? mag_abs : (mag_abs << (VALUE_BITS - 32));
    end else if (state == F_CONV) begin
      pend.digits <= dd_next;
      shifter     <= shifter << 1;
    end
  end

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (state == F_CONV) |-> (count != '0))
    else $error("conversion running with no bits left");

endmodule

@@ hw/rtl/ifmt_queue.sv @@
// Two-entry queue of converted fields between front and back end.
// Depends on ifmt_pkg for the field descriptor type.
module ifmt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  output logic                  full,
  input  ifmt_pkg::field_desc_t wr_desc,
  output logic                  valid,
  input  logic                  rd,
  output ifmt_pkg::field_desc_t rd_desc
);
  import ifmt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  field_desc_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;
  assign rd_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr)
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd)
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_desc;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

@@ hw/rtl/ifmt_back.sv @@
// Back end: spells one converted field out as characters into an output register.
// Depends on ifmt_pkg. Phases run pad, sign, prefix, zero pad, digits, right pad.
module ifmt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ifmt_pkg::field_desc_t q_desc,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output ifmt_pkg::out_item_t   result
);
  import ifmt_pkg::*;

  back_state_t state, state_next, nxt_phase;
  field_desc_t cur, sel;
  logic [5:0]  pad, pad_load, sel_pad, len_load, cnt, cnt_next, nxt_len;
  logic        out_valid, advance, emit, last;
  logic [7:0]  ch;
  logic [6:0]  mask;
  logic [6:0][5:0] lens;
  logic        found;
  logic [ND_W-1:0] didx;

  assign advance = !out_valid || pop;
  assign empty   = !out_valid;

  always_comb begin
    len_load = 6'(q_desc.has_sign) + 6'(q_desc.npre) + 6'(q_desc.nd);
    pad_load = (q_desc.width > len_load) ? (q_desc.width - len_load) : 6'd0;
    sel      = (state == B_IDLE) ? q_desc : cur;
    sel_pad  = (state == B_IDLE) ? pad_load : pad;
  end

  // Length of each phase and the first nonempty phase after the current one.
  always_comb begin
    lens[B_IDLE]   = 6'd0;
    lens[B_LPAD]   = (!sel.left && !sel.zpad) ? sel_pad : 6'd0;
    lens[B_SIGN]   = 6'(sel.has_sign);
    lens[B_PREFIX] = 6'(sel.npre);
    lens[B_ZPAD]   = (!sel.left && sel.zpad) ? sel_pad : 6'd0;
    lens[B_DIGIT]  = 6'(sel.nd);
    lens[B_RPAD]   = sel.left ? sel_pad : 6'd0;
    for (int k = 0; k < 7; k++) mask[k] = (lens[k] != 6'd0);

    nxt_phase = B_IDLE;
    nxt_len   = 6'd0;
    found     = 1'b0;
    for (int k = 1; k < 7; k++) begin
      if (!found && (3'(k) > 3'(state)) && mask[k]) begin
        found     = 1'b1;
        nxt_phase = back_state_t'(3'(k));
        nxt_len   = lens[k];
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state) inside
      B_IDLE: begin
        if (q_valid) begin
          state_next = nxt_phase;
          cnt_next   = nxt_len;
        end
      end
      B_LPAD, B_SIGN, B_PREFIX, B_ZPAD, B_DIGIT, B_RPAD: begin
        if (advance) begin
          if (cnt == 6'd1) begin
            state_next = nxt_phase;
            cnt_next   = nxt_len;
          end else begin
            cnt_next = cnt - 6'd1;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && q_valid;
    emit  = (state != B_IDLE) && advance;
    last  = (cnt == 6'd1) && (nxt_phase == B_IDLE);
    didx  = cnt[ND_W-1:0] - 1'b1;
    unique case (state)
      B_SIGN:   ch = cur.sign_char;
      B_PREFIX: ch = (cnt == 6'd2) ? CHAR_ZERO : cur.pfx_last;
      B_ZPAD:   ch = CHAR_ZERO;
      B_DIGIT:  ch = digit_char(cur.digits[didx], cur.upper);
      default:  ch = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (advance) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
      pad <= pad_load;
    end
    if (emit) begin
      result.out_char  <= ch;
      result.last_char <= last;
    end
  end

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> (cnt != 6'd0))
    else $error("emitting phase with empty count");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != B_IDLE))
    else $error("field loaded but no phase started");

endmodule

@@ hw/rtl/integer_field_formatter.sv @@
// Top level of the integer field formatter: printf-style integer text, one char per result.
// Depends on ifmt_pkg, ifmt_front, ifmt_queue and ifmt_back.
//
//   channel   handshake        payload                 direction
//   request   push / full      ifmt_pkg::in_item_t     in
//   result    empty / pop      ifmt_pkg::out_item_t    out
//
// Flow: a decimal request holds the front for one BCD conversion step per bit (32-bit
//   or long value); octal, hex and pointer requests skip that loop, and an unknown kind
//   is dropped. The back loads a field, then emits one character per cycle while
//   results are popped, up to 63; a two-entry queue lets the next conversion overlap.
// Reset (rst, synchronous) empties the queue and returns both ends to idle.
// Stalls: a held result stays in the output register; the front converts until the queue fills.
module integer_field_formatter #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ifmt_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output ifmt_pkg::out_item_t result
);
  import ifmt_pkg::*;

  logic        q_push, q_full, q_valid, q_pop;
  field_desc_t q_wr_desc, q_rd_desc;

  // Accept and convert requests.
  ifmt_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .q_push (q_push),
    .q_full (q_full),
    .q_desc (q_wr_desc)
  );

  // Hold converted fields until the back end is free.
  ifmt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .full   (q_full),
    .wr_desc(q_wr_desc),
    .valid  (q_valid),
    .rd     (q_pop),
    .rd_desc(q_rd_desc)
  );

  // Spell fields out, one transfer per character.
  ifmt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_desc (q_rd_desc),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ sim/formatter_checker.sv @@
`timescale 1ns / 1ps
// Checker for the integer field formatter: watches the request and result channels.
// It predicts the characters of each accepted request and compares every transfer out.
// Depends on ifmt_pkg for the payload types, conversion kinds and character codes.
module formatter_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  ifmt_pkg::in_item_t  request,
  input  logic                empty,
  input  logic                pop,
  input  ifmt_pkg::out_item_t result,
  output int                  errors,
  output int                  pending
);
  import ifmt_pkg::*;

  out_item_t expected_chars[$];
  out_item_t want;

  task automatic report_mismatch(input string what);
    if (errors < 100) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  // Spell out one conversion request and queue its characters, last one marked.
  function automatic void format_field(input in_item_t req);
    logic [63:0] mask;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [7:0]  d;
    logic [7:0]  digs[24];
    logic [7:0]  text[$];
    logic [7:0]  sign_ch;
    logic        has_sign;
    logic        long_value;
    logic        upper;
    logic        is_zero;
    int          nd;
    int          npre;
    int          len;
    int          pad;
    out_item_t   e;

    if (req.kind > KIND_PTR) return;

    long_value = (req.kind == KIND_PTR) || req.is_long;
    mask       = long_value ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    mag        = req.value_bits & mask;
    is_zero    = (mag == 64'd0);
    has_sign   = 1'b0;
    sign_ch    = CHAR_SPACE;

    if (req.kind == KIND_SDEC) begin
      if (long_value ? mag[63] : mag[31]) begin
        has_sign = 1'b1;
        sign_ch  = CHAR_MINUS;
        mag      = (~mag + 64'd1) & mask;
      end else if (req.force_plus) begin
        has_sign = 1'b1;
        sign_ch  = CHAR_PLUS;
      end else if (req.space_sign) begin
        has_sign = 1'b1;
      end
    end

    upper = (req.kind == KIND_HEXU);
    if (req.kind == KIND_OCT) radix = 64'd8;
    else if (req.kind >= KIND_HEXL) radix = 64'd16;
    else radix = 64'd10;

    // Collect digits least significant first.
    nd = 0;
    do begin
      d = 8'(mag % radix);
      digs[nd] = (d <= 8'd9) ? CHAR_ZERO + d : (upper ? HEX_UPPER_OFS : HEX_LOWER_OFS) + d;
      nd++;
      mag = mag / radix;
    end while (mag != 64'd0);

    npre = 0;
    if (req.kind == KIND_OCT && req.alt_prefix) begin
      if (!is_zero) npre = 1;
    end else if (req.kind == KIND_PTR ||
                 ((req.kind == KIND_HEXL || req.kind == KIND_HEXU) && req.alt_prefix)) begin
      if (req.kind == KIND_PTR || !is_zero) npre = 2;
    end

    len = (has_sign ? 1 : 0) + npre + nd;
    pad = (int'(req.field_width) > len) ? int'(req.field_width) - len : 0;

    if (!req.left_justify && !req.zero_pad) repeat (pad) text.push_back(CHAR_SPACE);
    if (has_sign) text.push_back(sign_ch);
    if (npre >= 1) text.push_back(CHAR_ZERO);
    if (npre == 2) text.push_back(upper ? CHAR_UPPER_X : CHAR_LOWER_X);
    if (!req.left_justify && req.zero_pad) repeat (pad) text.push_back(CHAR_ZERO);
    for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
    if (req.left_justify) repeat (pad) text.push_back(CHAR_SPACE);

    foreach (text[i]) begin
      e.out_char  = text[i];
      e.last_char = (i == text.size() - 1);
      expected_chars.push_back(e);
    end
  endfunction

  // Check the outgoing transfer before queueing the incoming one.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    result.out_char, result.last_char));
        end else begin
          want = expected_chars.pop_front();
          if (result.out_char !== want.out_char)
            report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                      result.out_char, want.out_char));
          if (result.last_char !== want.last_char)
            report_mismatch($sformatf("last_char %0b, want %0b on char 0x%02h",
                                      result.last_char, want.last_char, want.out_char));
        end
      end
      if (push && !full) format_field(request);
    end
    pending <= expected_chars.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the integer field formatter testbench: clock, reset, request stimulus, pop stalls.
// Depends on ifmt_pkg, integer_field_formatter and formatter_checker.
module testbench;
  import ifmt_pkg::*;

  // Kinds the block must drop without emitting anything.
  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  // Flag bundle for directed requests: {left, plus, space, zero pad, prefix}.
  localparam logic [4:0] FL_NONE  = 5'b00000;
  localparam logic [4:0] FL_LEFT  = 5'b10000;
  localparam logic [4:0] FL_PLUS  = 5'b01000;
  localparam logic [4:0] FL_SPACE = 5'b00100;
  localparam logic [4:0] FL_ZPAD  = 5'b00010;
  localparam logic [4:0] FL_ALT   = 5'b00001;

  localparam int RANDOM_REQUESTS = 145;
  // Worst case per request: 63 chars each behind the longest pop stall, plus send gap
  // and conversion time; about 180 requests, then taken several times over.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  request = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  int        errors;
  int        pending;
  int        cycle_count;
  int        stall_left = 0;
  logic      pop_idle = 1'b0;
  logic      send_idle;
  int        sent;
  in_item_t  req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_field_formatter i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  formatter_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  // Gap length: mostly short, sometimes longer, rarely a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk(input logic [2:0] k, input logic [63:0] v,
                                  input logic lng, input logic [5:0] w,
                                  input logic [4:0] f);
    in_item_t r;
    r.kind         = k;
    r.value_bits   = v;
    r.is_long      = lng;
    r.field_width  = w;
    r.left_justify = f[4];
    r.force_plus   = f[3];
    r.space_sign   = f[2];
    r.zero_pad     = f[1];
    r.alt_prefix   = f[0];
    return r;
  endfunction

  // Bias values toward zero, all ones, single bits, small numbers and the
  // 32-bit sign boundary; the rest is fully random.
  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 20));
      4: return {32'($urandom), $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic in_item_t random_request(input logic [2:0] k);
    int r;
    logic [5:0] w;
    r = $urandom_range(0, 99);
    if (r < 75) w = 6'($urandom_range(0, 16));
    else if (r < 95) w = 6'($urandom_range(17, 40));
    else w = 6'($urandom_range(41, 63));
    return mk(k, random_value(), 1'($urandom_range(0, 1)), w, 5'($urandom_range(0, 31)));
  endfunction

  // Drive one request and hold it until the block takes the transfer.
  // Leave push high on return so back-to-back requests need no extra edge.
  task automatic send(input in_item_t r);
    if (send_idle && $urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
  endtask

  // Drop push and hold off until every expected character has been popped.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: pop steadily, or when idling is on, start stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pop_idle && $urandom_range(0, 3) == 0) begin
      pop        <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    send_idle = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling on either side.
    send(mk(KIND_SDEC, 64'h0000_0000_8000_0000, 1'b0, 6'd0, FL_NONE));
    send(mk(KIND_SDEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, FL_PLUS));
    send(mk(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd25, FL_PLUS));
    send(mk(KIND_SDEC, 64'h0, 1'b0, 6'd0, FL_SPACE));
    // Upper half is ignored for a 32-bit value; plus wins over space.
    send(mk(KIND_SDEC, 64'hFFFF_FFFF_0000_0005, 1'b0, 6'd6, FL_PLUS | FL_SPACE));
    send(mk(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FF85, 1'b1, 6'd12, FL_ZPAD));
    // Unsigned kinds ignore plus and space and never go negative.
    send(mk(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0, FL_PLUS | FL_SPACE));
    send(mk(KIND_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, 6'd5, FL_SPACE));
    send(mk(KIND_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd30, FL_ALT | FL_ZPAD));
    send(mk(KIND_OCT, 64'h0, 1'b0, 6'd4, FL_ALT));
    send(mk(KIND_OCT, 64'h8, 1'b0, 6'd0, FL_NONE));
    send(mk(KIND_HEXL, 64'h0, 1'b1, 6'd0, FL_ALT));
    send(mk(KIND_HEXL, 64'hFF, 1'b0, 6'd10, FL_ALT | FL_ZPAD));
    // Left justify overrides zero padding.
    send(mk(KIND_HEXU, 64'hDEAD_BEEF, 1'b0, 6'd20, FL_ALT | FL_LEFT | FL_ZPAD));
    send(mk(KIND_HEXU, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, FL_ALT));
    // Pointers: always 64 bits and prefixed, sign flags ignored.
    send(mk(KIND_PTR, 64'h0, 1'b0, 6'd0, FL_NONE));
    send(mk(KIND_PTR, 64'hABCD_0000_1234_5678, 1'b0, 6'd24,
            FL_PLUS | FL_SPACE | FL_ZPAD));
    send(mk(KIND_BAD6, 64'h1234, 1'b1, 6'd10, FL_NONE));
    send(mk(KIND_BAD7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 5'b11111));
    send(mk(KIND_SDEC, 64'hFFFF_FFFF, 1'b0, 6'd63, FL_LEFT | FL_ZPAD | FL_PLUS));
    send(mk(KIND_UDEC, 64'h0, 1'b0, 6'd63, FL_NONE));
    send(mk(KIND_SDEC, 64'h1, 1'b0, 6'd63, FL_ZPAD | FL_SPACE));
    send(mk(KIND_HEXL, 64'h0123_4567_89AB_CDEF, 1'b1, 6'd0, FL_NONE));
    drain();

    // Random part with idling on both sides; hold a quiet stretch in the middle.
    pop_idle  <= 1'b1;
    send_idle = 1'b1;
    sent      = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (sent == 60) drain();
      if (sent == 100) begin
        pop_idle  <= 1'b0;
        send_idle = 1'b0;
      end else if (sent == 130) begin
        pop_idle  <= 1'b1;
        send_idle = 1'b1;
      end
      // Mix in the odd unknown kind; it does not count toward the total.
      if ($urandom_range(0, 99) < 4) begin
        req = random_request(3'($urandom_range(6, 7)));
      end else begin
        req = random_request(3'($urandom_range(0, 5)));
        sent++;
      end
      send(req);
    end
    drain();

    // Let any dropped request still in flight settle.
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
